>>> sv/radar_target_frame_decoder_unit_assert.svh
// Assertion macros for the checker of the radar target frame decoder.
`ifndef RADAR_TARGET_FRAME_DECODER_UNIT_ASSERT_SVH
`define RADAR_TARGET_FRAME_DECODER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RTFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RTFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/rtfd_pkg.sv
// Package with constants, types and helper functions of the radar target frame decoder.
package rtfd_pkg;

  localparam int BUFFER_BYTES_DEF = 64;
  localparam int TARGET_SLOTS_DEF = 3;

  localparam int HEADER_LEN       = 4;
  localparam int BYTES_PER_TARGET = 8;
  // Header plus footer; the footer is recognized from this frame length on.
  localparam int MIN_FOOTER_LEN   = 6;
  // Header, one target and the footer.
  localparam int MIN_FRAME_LEN    = HEADER_LEN + BYTES_PER_TARGET + 2;

  localparam logic [7:0] HDR_B0 = 8'hAA;
  localparam logic [7:0] HDR_B1 = 8'hFF;
  localparam logic [7:0] HDR_B2 = 8'h03;
  localparam logic [7:0] HDR_B3 = 8'h00;
  localparam logic [7:0] FTR_B0 = 8'h55;
  localparam logic [7:0] FTR_B1 = 8'hCC;

  localparam logic [15:0] MAX_RANGE_RST = 16'd8000;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_COLLECT,
    ST_CHK_READ,
    ST_CHK_SQX,
    ST_CHK_SQY,
    ST_CHK_CMP,
    ST_OUT_READ,
    ST_OUT_LOAD
  } rtfd_state_t;

  // Expected header byte at a given match position.
  function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = HDR_B0;
      2'd1:    b = HDR_B1;
      2'd2:    b = HDR_B2;
      default: b = HDR_B3;
    endcase
    return b;
  endfunction

  // Sign-magnitude field (bit 15 set means positive) to two's complement.
  function automatic logic signed [15:0] sm_to_int(input logic [15:0] raw);
    logic [15:0] mag;
    mag = {1'b0, raw[14:0]};
    return raw[15] ? mag : (~mag + 16'd1);
  endfunction

endpackage

>>> sv/radar_target_frame_decoder_unit.sv
// Top level of the radar target frame decoder: byte parser, frame memory and slot decoder.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+----------------------------------------
//   cfg     | in        | cfg_wr_en (no wait)  | cfg_max_range_mm
//   in      | in        | in_valid / in_ready  | in_rx_byte
//   out     | out       | out_valid / out_ready| target id, valid flag, x, y, speed, ...
//
// While hunting for the header or collecting payload the block takes one byte per cycle.
// A footer that closes a well-formed frame with n targets (n clipped to TARGET_SLOTS) drops
// in_ready until every slot is emitted, a time set by the single read port of the
// frame memory: each target's 8 bytes are read twice, one by one, once to check its range
// and once to emit its record. A low out_ready stretches the emit pass. Reset is
// synchronous and clears only control state; the frame memory is not cleared since a
// frame only reads bytes it wrote itself.
module radar_target_frame_decoder_unit #(
  parameter int BUFFER_BYTES = rtfd_pkg::BUFFER_BYTES_DEF,
  parameter int TARGET_SLOTS = rtfd_pkg::TARGET_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_max_range_mm,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_target_id,
  output logic               out_target_valid,
  output logic signed [15:0] out_pos_x_mm,
  output logic signed [15:0] out_pos_y_mm,
  output logic signed [15:0] out_speed_cm_s,
  output logic [15:0]        out_resolution_mm,
  output logic               out_frame_has_target,
  output logic               out_last_slot
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int LW = $clog2(BUFFER_BYTES + 1);
  localparam int SW = (TARGET_SLOTS > 1) ? $clog2(TARGET_SLOTS) : 1;
  localparam int NW = $clog2(TARGET_SLOTS + 1);

  // Control state.
  rtfd_pkg::rtfd_state_t state_r, state_nxt;
  logic [1:0]              hdr_idx_r, hdr_idx_nxt;
  logic [LW-1:0]           frame_len_r, frame_len_nxt;
  logic [NW-1:0]           n_tgt_r, n_tgt_nxt;
  logic [SW-1:0]           slot_r, slot_nxt;
  logic [AW-1:0]           addr_r, addr_nxt;
  logic [3:0]              issue_cnt_r, issue_cnt_nxt;
  logic [2:0]              cap_cnt_r, cap_cnt_nxt;
  logic                    rd_vld_r;
  logic [TARGET_SLOTS-1:0] ok_r, ok_nxt;
  logic [15:0]             max_range_r;
  logic                    out_valid_r, out_valid_nxt;

  // Payload state.
  logic [7:0]  prev_byte_r, prev_byte_nxt;
  logic [7:0]  rd_data_r;
  logic [63:0] tgt_r, tgt_nxt;
  logic [29:0] sqx_r, sqx_nxt;
  logic [29:0] sqy_r, sqy_nxt;
  logic [31:0] limit_r;

  logic [1:0]         out_id_r, out_id_nxt;
  logic               out_tv_r, out_tv_nxt;
  logic signed [15:0] out_x_r, out_x_nxt;
  logic signed [15:0] out_y_r, out_y_nxt;
  logic signed [15:0] out_s_r, out_s_nxt;
  logic [15:0]        out_res_r, out_res_nxt;
  logic               out_fht_r, out_fht_nxt;
  logic               out_last_r, out_last_nxt;

  // The frame memory: one write port for incoming bytes, one registered read port.
  logic [7:0] frame_mem [BUFFER_BYTES];

  logic          in_fire;
  logic          mem_we;
  logic          rd_issue;
  logic          rd_done;
  logic [LW-1:0] len_new;
  logic [LW-1:0] payload_len;
  logic [LW-1:0] tgt_cnt;
  logic          footer_hit;
  logic          frame_ok;
  logic [NW:0]   slot_inc;
  logic          slot_more;
  logic          last_slot;
  logic          out_free;
  logic          hdr_hit;

  assign in_ready = (state_r == rtfd_pkg::ST_HUNT) || (state_r == rtfd_pkg::ST_COLLECT);
  assign in_fire  = in_valid && in_ready;

  // Frame length after storing the current byte, and the footer test on the last two bytes.
  assign len_new     = frame_len_r + LW'(1);
  assign payload_len = len_new - LW'(rtfd_pkg::MIN_FOOTER_LEN);
  assign tgt_cnt     = payload_len >> 3;
  assign footer_hit  = (len_new >= LW'(rtfd_pkg::MIN_FOOTER_LEN)) &&
                       (prev_byte_r == rtfd_pkg::FTR_B0) && (in_rx_byte == rtfd_pkg::FTR_B1);
  assign frame_ok    = (len_new >= LW'(rtfd_pkg::MIN_FRAME_LEN)) && (payload_len[2:0] == 3'd0);
  assign hdr_hit     = (in_rx_byte == rtfd_pkg::hdr_byte(hdr_idx_r));

  // A target read is done when the eighth byte comes out of the memory.
  assign rd_done   = rd_vld_r && (cap_cnt_r == 3'd7);
  assign slot_inc  = (NW + 1)'(slot_r) + (NW + 1)'(1);
  assign slot_more = slot_inc < {1'b0, n_tgt_r};
  assign last_slot = (slot_r == SW'(TARGET_SLOTS - 1));
  // The output register can take a record when it is empty or being drained.
  assign out_free  = !out_valid_r || out_ready;

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rtfd_pkg::ST_HUNT: begin
        if (in_fire && hdr_hit && (hdr_idx_r == 2'(rtfd_pkg::HEADER_LEN - 1))) begin
          state_nxt = rtfd_pkg::ST_COLLECT;
        end
      end
      rtfd_pkg::ST_COLLECT: begin
        if (in_fire) begin
          if (footer_hit) begin
            state_nxt = frame_ok ? rtfd_pkg::ST_CHK_READ : rtfd_pkg::ST_HUNT;
          end else if (len_new == LW'(BUFFER_BYTES)) begin
            state_nxt = rtfd_pkg::ST_HUNT;
          end
        end
      end
      rtfd_pkg::ST_CHK_READ: begin
        if (rd_done) begin
          state_nxt = rtfd_pkg::ST_CHK_SQX;
        end
      end
      rtfd_pkg::ST_CHK_SQX: state_nxt = rtfd_pkg::ST_CHK_SQY;
      rtfd_pkg::ST_CHK_SQY: state_nxt = rtfd_pkg::ST_CHK_CMP;
      rtfd_pkg::ST_CHK_CMP: begin
        state_nxt = slot_more ? rtfd_pkg::ST_CHK_READ : rtfd_pkg::ST_OUT_READ;
      end
      rtfd_pkg::ST_OUT_READ: begin
        if (rd_done) begin
          state_nxt = rtfd_pkg::ST_OUT_LOAD;
        end
      end
      rtfd_pkg::ST_OUT_LOAD: begin
        if (out_free) begin
          if (last_slot) begin
            state_nxt = rtfd_pkg::ST_HUNT;
          end else if (slot_more) begin
            state_nxt = rtfd_pkg::ST_OUT_READ;
          end
        end
      end
      default: state_nxt = rtfd_pkg::ST_HUNT;
    endcase
  end

  // Datapath and output values for each state.
  always_comb begin
    hdr_idx_nxt   = hdr_idx_r;
    frame_len_nxt = frame_len_r;
    prev_byte_nxt = prev_byte_r;
    n_tgt_nxt     = n_tgt_r;
    slot_nxt      = slot_r;
    addr_nxt      = addr_r;
    issue_cnt_nxt = issue_cnt_r;
    cap_cnt_nxt   = cap_cnt_r;
    tgt_nxt       = tgt_r;
    sqx_nxt       = sqx_r;
    sqy_nxt       = sqy_r;
    ok_nxt        = ok_r;
    mem_we        = 1'b0;
    rd_issue      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_id_nxt    = out_id_r;
    out_tv_nxt    = out_tv_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_s_nxt     = out_s_r;
    out_res_nxt   = out_res_r;
    out_fht_nxt   = out_fht_r;
    out_last_nxt  = out_last_r;

    // Bytes read from memory shift in from the top, so the target ends up little endian.
    if (rd_vld_r) begin
      tgt_nxt     = {rd_data_r, tgt_r[63:8]};
      cap_cnt_nxt = cap_cnt_r + 3'd1;
    end

    case (state_r)
      rtfd_pkg::ST_HUNT: begin
        if (in_fire) begin
          if (hdr_hit) begin
            if (hdr_idx_r == 2'(rtfd_pkg::HEADER_LEN - 1)) begin
              hdr_idx_nxt   = 2'd0;
              frame_len_nxt = LW'(rtfd_pkg::HEADER_LEN);
            end else begin
              hdr_idx_nxt = hdr_idx_r + 2'd1;
            end
          end else if (in_rx_byte == rtfd_pkg::HDR_B0) begin
            hdr_idx_nxt = 2'd1;
          end else begin
            hdr_idx_nxt = 2'd0;
          end
        end
      end
      rtfd_pkg::ST_COLLECT: begin
        if (in_fire) begin
          mem_we        = 1'b1;
          prev_byte_nxt = in_rx_byte;
          frame_len_nxt = len_new;
          if (footer_hit || (len_new == LW'(BUFFER_BYTES))) begin
            frame_len_nxt = '0;
          end
          if (footer_hit && frame_ok) begin
            n_tgt_nxt     = (tgt_cnt > LW'(TARGET_SLOTS)) ? NW'(TARGET_SLOTS) : NW'(tgt_cnt);
            slot_nxt      = '0;
            addr_nxt      = AW'(rtfd_pkg::HEADER_LEN);
            issue_cnt_nxt = '0;
            cap_cnt_nxt   = '0;
            ok_nxt        = '0;
          end
        end
      end
      rtfd_pkg::ST_CHK_READ, rtfd_pkg::ST_OUT_READ: begin
        if (issue_cnt_r != 4'(rtfd_pkg::BYTES_PER_TARGET)) begin
          rd_issue      = 1'b1;
          addr_nxt      = addr_r + AW'(1);
          issue_cnt_nxt = issue_cnt_r + 4'd1;
        end
        if (rd_done) begin
          issue_cnt_nxt = '0;
        end
      end
      rtfd_pkg::ST_CHK_SQX: begin
        sqx_nxt = 30'(tgt_r[14:0]) * 30'(tgt_r[14:0]);
      end
      rtfd_pkg::ST_CHK_SQY: begin
        sqy_nxt = 30'(tgt_r[30:16]) * 30'(tgt_r[30:16]);
      end
      rtfd_pkg::ST_CHK_CMP: begin
        ok_nxt[slot_r] = (tgt_r[63:48] != 16'd0) && ((32'(sqx_r) + 32'(sqy_r)) <= limit_r);
        if (slot_more) begin
          slot_nxt = slot_r + SW'(1);
        end else begin
          slot_nxt = '0;
          addr_nxt = AW'(rtfd_pkg::HEADER_LEN);
        end
      end
      rtfd_pkg::ST_OUT_LOAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = 2'(slot_inc);
          out_tv_nxt    = ok_r[slot_r];
          out_x_nxt     = ok_r[slot_r] ? rtfd_pkg::sm_to_int(tgt_r[15:0])  : 16'sd0;
          out_y_nxt     = ok_r[slot_r] ? rtfd_pkg::sm_to_int(tgt_r[31:16]) : 16'sd0;
          out_s_nxt     = ok_r[slot_r] ? rtfd_pkg::sm_to_int(tgt_r[47:32]) : 16'sd0;
          out_res_nxt   = ok_r[slot_r] ? tgt_r[63:48] : 16'd0;
          out_fht_nxt   = |ok_r;
          out_last_nxt  = last_slot;
          if (!last_slot) begin
            slot_nxt = slot_r + SW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Frame memory. Writes only while collecting; read data is used only while decoding.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[frame_len_r[AW-1:0]] <= in_rx_byte;
    end
    rd_data_r <= frame_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rtfd_pkg::ST_HUNT;
      hdr_idx_r   <= '0;
      frame_len_r <= '0;
      n_tgt_r     <= '0;
      slot_r      <= '0;
      addr_r      <= '0;
      issue_cnt_r <= '0;
      cap_cnt_r   <= '0;
      rd_vld_r    <= 1'b0;
      ok_r        <= '0;
      max_range_r <= rtfd_pkg::MAX_RANGE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hdr_idx_r   <= hdr_idx_nxt;
      frame_len_r <= frame_len_nxt;
      n_tgt_r     <= n_tgt_nxt;
      slot_r      <= slot_nxt;
      addr_r      <= addr_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      cap_cnt_r   <= cap_cnt_nxt;
      rd_vld_r    <= rd_issue;
      ok_r        <= ok_nxt;
      if (cfg_wr_en) begin
        max_range_r <= cfg_max_range_mm;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers; the squared range limit follows the register in the cycle after,
  // before the checks of any frame whose footer arrives with or after the write.
  always_ff @(posedge clk) begin
    prev_byte_r <= prev_byte_nxt;
    tgt_r       <= tgt_nxt;
    sqx_r       <= sqx_nxt;
    sqy_r       <= sqy_nxt;
    limit_r     <= 32'(max_range_r) * 32'(max_range_r);
    out_id_r    <= out_id_nxt;
    out_tv_r    <= out_tv_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_s_r     <= out_s_nxt;
    out_res_r   <= out_res_nxt;
    out_fht_r   <= out_fht_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_target_id        = out_id_r;
  assign out_target_valid     = out_tv_r;
  assign out_pos_x_mm         = out_x_r;
  assign out_pos_y_mm         = out_y_r;
  assign out_speed_cm_s       = out_s_r;
  assign out_resolution_mm    = out_res_r;
  assign out_frame_has_target = out_fht_r;
  assign out_last_slot        = out_last_r;

endmodule

>>> sv/rtfd_checker.sv
// Port-level checker for the radar target frame decoder, bound to its top level.
`include "radar_target_frame_decoder_unit_assert.svh"

module rtfd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_target_id,
  input logic               out_target_valid,
  input logic signed [15:0] out_pos_x_mm,
  input logic signed [15:0] out_pos_y_mm,
  input logic signed [15:0] out_speed_cm_s,
  input logic [15:0]        out_resolution_mm,
  input logic               out_frame_has_target,
  input logic               out_last_slot
);

  logic [68:0] rec_bits;
  logic        vals_zero;

  assign rec_bits  = {out_target_id, out_target_valid, out_pos_x_mm, out_pos_y_mm,
                      out_speed_cm_s, out_resolution_mm, out_frame_has_target,
                      out_last_slot};
  assign vals_zero = (out_pos_x_mm == 16'sd0) && (out_pos_y_mm == 16'sd0) &&
                     (out_speed_cm_s == 16'sd0) && (out_resolution_mm == 16'd0);

  // A stalled record keeps its contents.
  `RTFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(rec_bits), "stalled record changed")

  // An invalid slot carries zero in every value field.
  `RTFD_ASSERT_NOW(a_invalid_zero, out_valid && !out_target_valid, vals_zero, "invalid slot with nonzero values")

  // A valid slot has a resolution and marks its frame as holding a target.
  `RTFD_ASSERT_NOW(a_valid_flags, out_valid && out_target_valid, out_frame_has_target && (out_resolution_mm != 16'd0), "valid slot with inconsistent flags")

  // A presented record never carries unknown bits.
  `RTFD_ASSERT_NOW(a_known, out_valid, !$isunknown(rec_bits), "record with unknown bits")

endmodule

bind radar_target_frame_decoder_unit rtfd_checker u_rtfd_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_target_id        (out_target_id),
  .out_target_valid     (out_target_valid),
  .out_pos_x_mm         (out_pos_x_mm),
  .out_pos_y_mm         (out_pos_y_mm),
  .out_speed_cm_s       (out_speed_cm_s),
  .out_resolution_mm    (out_resolution_mm),
  .out_frame_has_target (out_frame_has_target),
  .out_last_slot        (out_last_slot)
);

>>> test/tb.sv
// Self-checking testbench for the radar target frame decoder unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = rtfd_pkg::TARGET_SLOTS_DEF;
  localparam int BUF_BYTES = rtfd_pkg::BUFFER_BYTES_DEF;
  // Long enough to cover a full frame decode plus some slack.
  localparam int DRAIN_CYCLES = 150;
  localparam int PHASE_BYTES = 40;
  localparam logic [31:0] HDR_WORD = {rtfd_pkg::HDR_B3, rtfd_pkg::HDR_B2,
                                      rtfd_pkg::HDR_B1, rtfd_pkg::HDR_B0};

  // One decoded slot record as the block should present it.
  typedef struct packed {
    logic [1:0]  id;
    logic        vld;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] spd;
    logic [15:0] res;
    logic        has;
    logic        last;
  } slot_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_max_range_mm = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_target_id;
  logic        out_target_valid;
  logic signed [15:0] out_pos_x_mm;
  logic signed [15:0] out_pos_y_mm;
  logic signed [15:0] out_speed_cm_s;
  logic [15:0] out_resolution_mm;
  logic        out_frame_has_target;
  logic        out_last_slot;

  // Shadow copy of the block's parser state and its range register.
  logic [15:0] range_mm = rtfd_pkg::MAX_RANGE_RST;
  bit          in_frame = 1'b0;
  int          hdr_cnt = 0;
  logic [7:0]  frame_bytes [BUF_BYTES];
  int          frame_len = 0;

  // Bytes still to be sent and slot records still to be received.
  logic [7:0]  tx_bytes [$];
  slot_rec_t   slots_due [$];
  int          bytes_queued = 0;

  // When set, neither side inserts idle cycles.
  bit calm = 1'b0;

  int err_cnt = 0;
  int frames_decoded = 0;
  int frames_rejected = 0;
  int frames_dropped = 0;
  int recs_seen = 0;
  int recs_valid = 0;

  radar_target_frame_decoder_unit uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_max_range_mm     (cfg_max_range_mm),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_target_id        (out_target_id),
    .out_target_valid     (out_target_valid),
    .out_pos_x_mm         (out_pos_x_mm),
    .out_pos_y_mm         (out_pos_y_mm),
    .out_speed_cm_s       (out_speed_cm_s),
    .out_resolution_mm    (out_resolution_mm),
    .out_frame_has_target (out_frame_has_target),
    .out_last_slot        (out_last_slot)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sign-magnitude field to two's complement: bit 15 set means positive.
  function automatic logic [15:0] sm_value(input logic [15:0] raw);
    logic [15:0] mag;
    mag = {1'b0, raw[14:0]};
    return raw[15] ? mag : (16'd0 - mag);
  endfunction

  // Turns the collected frame into one record per slot, or rejects it when the
  // payload is short or not a whole number of targets.
  task automatic decode_frame();
    int                n;
    int                base;
    int                hits;
    longint unsigned   lim;
    longint unsigned   mx;
    longint unsigned   my;
    logic [15:0]       xr;
    logic [15:0]       yr;
    logic [15:0]       sr;
    logic [15:0]       rr;
    slot_rec_t         rec [SLOTS];
    if (frame_len < rtfd_pkg::MIN_FRAME_LEN ||
        ((frame_len - rtfd_pkg::MIN_FOOTER_LEN) % rtfd_pkg::BYTES_PER_TARGET) != 0) begin
      frames_rejected++;
      return;
    end
    n = (frame_len - rtfd_pkg::MIN_FOOTER_LEN) / rtfd_pkg::BYTES_PER_TARGET;
    if (n > SLOTS) n = SLOTS;
    lim = longint'(range_mm) * longint'(range_mm);
    hits = 0;
    for (int t = 0; t < SLOTS; t++) begin
      rec[t] = '0;
      rec[t].id = 2'(t + 1);
      rec[t].last = (t == SLOTS - 1);
      if (t < n) begin
        base = rtfd_pkg::HEADER_LEN + t * rtfd_pkg::BYTES_PER_TARGET;
        xr = {frame_bytes[base + 1], frame_bytes[base]};
        yr = {frame_bytes[base + 3], frame_bytes[base + 2]};
        sr = {frame_bytes[base + 5], frame_bytes[base + 4]};
        rr = {frame_bytes[base + 7], frame_bytes[base + 6]};
        mx = xr[14:0];
        my = yr[14:0];
        if (rr != 16'd0 && (mx * mx + my * my) <= lim) begin
          rec[t].vld = 1'b1;
          rec[t].x = sm_value(xr);
          rec[t].y = sm_value(yr);
          rec[t].spd = sm_value(sr);
          rec[t].res = rr;
          hits++;
        end
      end
    end
    for (int t = 0; t < SLOTS; t++) begin
      rec[t].has = (hits > 0);
      slots_due.push_back(rec[t]);
    end
    frames_decoded++;
  endtask

  // Advances the shadow parser by one accepted byte.
  task automatic absorb_rx_byte(input logic [7:0] b);
    if (!in_frame) begin
      if (b == HDR_WORD[8 * hdr_cnt +: 8]) begin
        frame_bytes[hdr_cnt] = b;
        hdr_cnt++;
        if (hdr_cnt == rtfd_pkg::HEADER_LEN) begin
          frame_len = rtfd_pkg::HEADER_LEN;
          in_frame = 1'b1;
        end
      end else if (b == rtfd_pkg::HDR_B0) begin
        // A mismatching 0xAA starts a fresh header match.
        frame_bytes[0] = b;
        hdr_cnt = 1;
      end else begin
        hdr_cnt = 0;
      end
    end else begin
      frame_bytes[frame_len] = b;
      frame_len++;
      // The footer wins even when this byte also fills the buffer.
      if (frame_len >= rtfd_pkg::MIN_FOOTER_LEN &&
          frame_bytes[frame_len - 2] == rtfd_pkg::FTR_B0 &&
          frame_bytes[frame_len - 1] == rtfd_pkg::FTR_B1) begin
        decode_frame();
        hdr_cnt = 0;
        frame_len = 0;
        in_frame = 1'b0;
      end else if (frame_len >= BUF_BYTES) begin
        frames_dropped++;
        hdr_cnt = 0;
        frame_len = 0;
        in_frame = 1'b0;
      end
    end
  endtask

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  // Byte driver. The shadow parser sees each byte at the edge where its
  // transaction completes, so expectations exist before any result can appear.
  always @(posedge clk) begin : byte_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) absorb_rx_byte(in_rx_byte);
      // A held byte is never changed until its transaction completes.
      if (!in_valid || in_ready) begin
        if (tx_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= 24)) begin
          in_valid <= 1'b1;
          in_rx_byte <= tx_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Each completed result transaction is matched against the
  // oldest expected slot record, field by field.
  always @(posedge clk) begin : result_monitor
    slot_rec_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        recs_seen++;
        if (slots_due.size() == 0) begin
          $error("slot record %0d arrived with none expected", out_target_id);
          err_cnt++;
        end else begin
          want = slots_due.pop_front();
          if (want.vld) recs_valid++;
          check_field("target_id", want.id, out_target_id);
          check_field("target_valid", want.vld, out_target_valid);
          check_field("pos_x_mm", $signed(want.x), out_pos_x_mm);
          check_field("pos_y_mm", $signed(want.y), out_pos_y_mm);
          check_field("speed_cm_s", $signed(want.spd), out_speed_cm_s);
          check_field("resolution_mm", want.res, out_resolution_mm);
          check_field("frame_has_target", want.has, out_frame_has_target);
          check_field("last_slot", want.last, out_last_slot);
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 24);
    end
  end

  task automatic push_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_header();
    for (int i = 0; i < rtfd_pkg::HEADER_LEN; i++) push_byte(HDR_WORD[8 * i +: 8]);
  endtask

  task automatic push_footer();
    push_byte(rtfd_pkg::FTR_B0);
    push_byte(rtfd_pkg::FTR_B1);
  endtask

  // Payload filler that can never form a footer.
  function automatic logic [7:0] fill_byte();
    return 8'($urandom_range(0, 8'h54));
  endfunction

  // One target, each field little endian.
  task automatic push_target(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] s, input logic [15:0] r);
    push_byte(x[7:0]); push_byte(x[15:8]);
    push_byte(y[7:0]); push_byte(y[15:8]);
    push_byte(s[7:0]); push_byte(s[15:8]);
    push_byte(r[7:0]); push_byte(r[15:8]);
  endtask

  // Position field spread around the current range: well inside, anywhere up
  // to the range, right on it, zero, or any magnitude at all.
  function automatic logic [15:0] rand_axis();
    int lim;
    int mag;
    lim = (range_mm > 32767) ? 32767 : int'(range_mm);
    case ($urandom_range(0, 4))
      0:       mag = $urandom_range(0, lim / 2);
      1:       mag = $urandom_range(0, lim);
      2:       mag = lim;
      3:       mag = 0;
      default: mag = $urandom_range(0, 32767);
    endcase
    return {1'($urandom_range(0, 1)), 15'(mag)};
  endfunction

  task automatic push_frame(input int n);
    logic [15:0] r;
    push_header();
    repeat (n) begin
      r = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom());
      push_target(rand_axis(), rand_axis(), 16'($urandom()), r);
    end
    push_footer();
  endtask

  // Mostly well-formed frames with random contents, mixed with line noise,
  // broken headers, misaligned payloads and the odd overflowing frame.
  task automatic random_traffic(input int budget);
    int start;
    int k;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      case ($urandom_range(0, 9))
        7: begin
          repeat ($urandom_range(1, 6))
            push_byte(($urandom_range(0, 9) == 0) ? rtfd_pkg::HDR_B0 : 8'($urandom()));
        end
        8: begin
          push_byte(rtfd_pkg::HDR_B0);
          if ($urandom_range(0, 1)) push_byte(rtfd_pkg::HDR_B1);
          if ($urandom_range(0, 1)) push_byte(rtfd_pkg::HDR_B2);
          push_byte(8'($urandom()));
        end
        9: begin
          push_header();
          if ($urandom_range(0, 5) == 0) begin
            repeat (BUF_BYTES - rtfd_pkg::HEADER_LEN) push_byte(fill_byte());
          end else begin
            k = $urandom_range(1, 30);
            if (k % rtfd_pkg::BYTES_PER_TARGET == 0) k++;
            repeat (k) push_byte(fill_byte());
            push_footer();
          end
        end
        default: begin
          k = $urandom_range(0, 19);
          if (k == 0) push_frame(0);
          else if (k < 15) push_frame($urandom_range(1, 3));
          else push_frame($urandom_range(4, 7));
        end
      endcase
    end
  endtask

  // Waits until every byte is in and every record is out, then lets the block
  // finish any decode of a frame that produced nothing.
  task automatic wait_idle();
    while (tx_bytes.size() != 0 || in_valid || slots_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_range(input logic [15:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_max_range_mm <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    range_mm = v;
  endtask

  initial begin : stimulus
    logic [15:0] ranges [5];
    ranges[0] = 16'd0;
    ranges[1] = 16'hFFFF;
    ranges[2] = 16'($urandom_range(1, 65534));
    ranges[3] = 16'd100;
    ranges[4] = rtfd_pkg::MAX_RANGE_RST;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames run with the range register still at its reset value.
    // A stray byte, then a header interrupted by a second 0xAA, which restarts
    // the match. One target sits exactly on the range limit, the next is one
    // millimetre beyond it, and the third slot is left empty.
    push_byte(8'h12);
    push_byte(rtfd_pkg::HDR_B0);
    push_byte(rtfd_pkg::HDR_B1);
    push_header();
    push_target(16'h8000 | 16'd8000, 16'h8000, 16'hFFFF, 16'hFFFF);
    push_target(16'd8001, 16'h0000, 16'h7FFF, 16'h0001);
    push_footer();
    // Four targets: negative zero in both positions, a zero resolution, a point far
    // out of range, and one more target than there are slots.
    push_header();
    push_target(16'h0000, 16'h0000, 16'h8000, 16'h0001);
    push_target(16'h8064, 16'h00C8, 16'h1234, 16'h0000);
    push_target(16'h7FFF, 16'hFFFF, 16'h0000, 16'h8000);
    push_target(16'h8001, 16'h8001, 16'h8001, 16'h0001);
    push_footer();
    // Header straight into the footer, then a payload of three loose bytes.
    push_header();
    push_footer();
    push_header();
    repeat (3) push_byte(fill_byte());
    push_footer();
    // The buffer fills without a footer and the frame is dropped.
    push_header();
    repeat (BUF_BYTES - rtfd_pkg::HEADER_LEN) push_byte(fill_byte());
    // The footer lands on the very last buffer byte and still ends the frame.
    push_header();
    repeat (BUF_BYTES - rtfd_pkg::HEADER_LEN - 2) push_byte(fill_byte());
    push_footer();
    // A full frame afterwards shows the parser is back in sync.
    push_frame(3);
    wait_idle();

    // Random phases, one per range setting; the all-ones range also runs with
    // both sides streaming without any idle cycle.
    for (int p = 0; p < 5; p++) begin
      write_range(ranges[p]);
      calm = (p == 1);
      random_traffic(PHASE_BYTES);
      wait_idle();
      calm = 1'b0;
    end

    $display("Sent %0d bytes: %0d frames decoded, %0d rejected, %0d dropped on overflow.",
             bytes_queued, frames_decoded, frames_rejected, frames_dropped);
    $display("Checked %0d slot records, %0d of them valid, over 6 range settings.",
             recs_seen, recs_valid);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Guard against a hang; the full run needs well under a tenth of this.
  initial begin : watchdog
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
